FILE: src/ctb_pkg.sv
// Shared constants, result codes and controller/datapath handshake types
// for the countdown timer bank. Depends on nothing.
`default_nettype none

package ctb_pkg;

	// Bank geometry and per-update result limit.
	localparam int NumSlots    = 16;
	localparam int SlotW       = $clog2(NumSlots);
	localparam int MaxResults  = 16;
	localparam int ResultCntW  = $clog2(MaxResults + 1);

	// Period after reset, in milliseconds.
	localparam logic [15:0] ResetPeriod = 16'd100;

	// Operation codes of an input item.
	localparam logic [1:0] OpStart  = 2'd0;
	localparam logic [1:0] OpCancel = 2'd1;
	localparam logic [1:0] OpQuery  = 2'd2;
	localparam logic [1:0] OpUpdate = 2'd3;

	// Result kinds.
	localparam logic [2:0] KindTick      = 3'd0;
	localparam logic [2:0] KindFinished  = 3'd1;
	localparam logic [2:0] KindStarted   = 3'd2;
	localparam logic [2:0] KindNoFree    = 3'd3;
	localparam logic [2:0] KindCancelled = 3'd4;
	localparam logic [2:0] KindInvalid   = 3'd5;
	localparam logic [2:0] KindRemaining = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;       // input transfer this cycle
		logic exec_answer;  // apply start/cancel/query and load its result
		logic clock_step;   // advance the millisecond clock
		logic scan_step;    // process the slot under the scan pointer
		logic flush_push;   // move the held scan result out, marked last
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_update;    // latched operation is a time update
		logic hit;          // slot under the pointer has expired
		logic scan_block;   // expired slot but no room to pass the held result on
		logic scan_end;     // pointer is at the last slot
		logic pend_valid;   // a scan result is held back
		logic out_free;     // output register can take a result this cycle
	} ctl_sts_t;

endpackage

`default_nettype wire

FILE: src/countdown_timer_bank.sv
// Top level of the countdown timer bank: controller plus datapath.
// Depends on ctb_pkg, ctb_ctrl and ctb_datapath.
`default_nettype none

// A bank of 16 countdown timers driven by a millisecond clock. Start, cancel
// and query items each give one result, which waits for a free output
// register. A time update advances the clock, then visits the slots one per
// cycle (the scan waits while a held result meets a stalled output register)
// in ascending order through a single deadline compare and add, and finishes
// by releasing the last event. Each expired slot yields a tick or finished result;
// an update with nothing expired yields no result. One item is in work at a
// time, and a result waiting in the output register does not hold off the
// next input transfer. The period register can be written at any time the
// bank is idle; the write is always taken.
module countdown_timer_bank (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        tick_period_ms,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         operation,
	input  wire logic [15:0]        tenths,
	input  wire logic signed [4:0]  timer_index,
	input  wire logic [31:0]        raw_ticks,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              kind,
	output logic [3:0]              slot,
	output logic signed [16:0]      remaining_count,
	output logic                    last
);

	ctb_pkg::ctl_cmd_t cmd;
	ctb_pkg::ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencer.
	ctb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot state and result path.
	ctb_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_valid       (cfg_valid),
		.tick_period_ms  (tick_period_ms),
		.operation       (operation),
		.tenths          (tenths),
		.timer_index     (timer_index),
		.raw_ticks       (raw_ticks),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.slot            (slot),
		.remaining_count (remaining_count),
		.last            (last)
	);

`ifndef SYNTHESIS
	// No scan result may be left behind once the bank is idle again.
	a_no_pend_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.pend_valid)
		else $error("held scan result left over while idle");

	// A scan step that passes a held result on must find the output free.
	a_scan_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && sts.hit && sts.pend_valid) |-> sts.out_free)
		else $error("scan result pushed into a full output register");

	// Every result loaded while the output is stalled overwrites nothing.
	a_out_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !(cmd.exec_answer || cmd.flush_push))
		else $error("pending output result overwritten");
`endif

endmodule

`default_nettype wire

FILE: src/ctb_ctrl.sv
// Sequencing controller of the countdown timer bank.
// Uses ctb_pkg for the command and status types.
`default_nettype none

module ctb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ctb_pkg::ctl_sts_t sts,
	output ctb_pkg::ctl_cmd_t      cmd
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StExec  = 2'd1;
	localparam logic [1:0] StScan  = 2'd2;
	localparam logic [1:0] StFlush = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Only one item is in work at a time.
	assign in_stall = (state_q != StIdle);

	// Command decode and next state.
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cmd.accept  = in_valid && (state_q == StIdle);
		case (state_q)
			StIdle: begin
				if (cmd.accept) begin
					state_d = StExec;
				end
			end
			StExec: begin
				if (sts.is_update) begin
					cmd.clock_step = 1'b1;
					state_d        = StScan;
				end else if (sts.out_free) begin
					cmd.exec_answer = 1'b1;
					state_d         = StIdle;
				end
			end
			StScan: begin
				if (!sts.scan_block) begin
					cmd.scan_step = 1'b1;
					if (sts.scan_end) begin
						state_d = StFlush;
					end
				end
			end
			StFlush: begin
				if (!sts.pend_valid) begin
					state_d = StIdle;
				end else if (sts.out_free) begin
					cmd.flush_push = 1'b1;
					state_d        = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/ctb_datapath.sv
// Datapath of the countdown timer bank: slot state, millisecond clock,
// scan pointer, held scan result and output register. Uses ctb_pkg.
`default_nettype none

module ctb_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctb_pkg::ctl_cmd_t  cmd,
	output ctb_pkg::ctl_sts_t       sts,
	input  wire logic               cfg_valid,
	input  wire logic [15:0]        tick_period_ms,
	input  wire logic [1:0]         operation,
	input  wire logic [15:0]        tenths,
	input  wire logic signed [4:0]  timer_index,
	input  wire logic [31:0]        raw_ticks,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              kind,
	output logic [3:0]              slot,
	output logic signed [16:0]      remaining_count,
	output logic                    last
);

	localparam int SW = ctb_pkg::SlotW;
	localparam int NS = ctb_pkg::NumSlots;
	localparam int RW = ctb_pkg::ResultCntW;

	// Configuration and timebase.
	logic [15:0]            period_q;
	logic [63:0]            clock_q;
	logic [31:0]            prev_q;

	// Per-slot state.
	logic [NS-1:0]          running_q;
	logic signed [16:0]     count_q [NS];
	logic [63:0]            deadline_q [NS];

	// Latched input item and scan bookkeeping.
	logic [1:0]             op_q;
	logic [15:0]            tenths_q;
	logic signed [4:0]      idx_q;
	logic [31:0]            now_q;
	logic [SW-1:0]          ptr_q;
	logic [RW-1:0]          nres_q;

	// Scan result held back until it is known whether it is the last.
	logic                   pend_valid_q;
	logic [2:0]             pend_kind_q;
	logic [3:0]             pend_slot_q;
	logic signed [16:0]     pend_count_q;

	// Output register.
	logic                   out_valid_q;
	logic [2:0]             out_kind_q;
	logic [3:0]             out_slot_q;
	logic signed [16:0]     out_count_q;
	logic                   out_last_q;

	logic                   out_free;
	logic                   idx_bad;
	logic                   free_found;
	logic [SW-1:0]          free_idx;
	logic signed [16:0]     cnt_rd;
	logic signed [16:0]     cnt_dec;
	logic [63:0]            dl_rd;
	logic [63:0]            dl_next;
	logic                   cnt_pos;
	logic                   hit;
	logic [31:0]            elapsed;
	logic signed [16:0]     start_cnt;
	logic [2:0]             ans_kind;
	logic [3:0]             ans_slot;
	logic signed [16:0]     ans_count;
	logic                   push_scan;
	logic                   push_any;
	logic                   do_start;
	logic                   do_cancel;

	// Slot reads all go through the scan/query pointer.
	assign cnt_rd  = count_q[ptr_q];
	assign dl_rd   = deadline_q[ptr_q];
	assign cnt_dec = cnt_rd - 17'sd1;
	assign cnt_pos = (cnt_dec > 17'sd0);
	assign dl_next = dl_rd + {48'd0, period_q};

	// A running slot expires when the clock has strictly passed its deadline and fewer than MaxResults results were given.
	assign hit = running_q[ptr_q] && (clock_q > dl_rd)
		&& (nres_q < RW'(ctb_pkg::MaxResults));

	assign elapsed   = now_q - prev_q;
	assign start_cnt = $signed({1'b0, tenths_q}) - 17'sd1;
	assign idx_bad   = idx_q[4] || ({1'b0, idx_q[3:0]} >= 5'(NS));
	assign out_free  = !out_valid_q || !out_stall;

	// Lowest-numbered idle slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (!running_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Result of a start, cancel or query.
	always_comb begin
		ans_kind  = ctb_pkg::KindInvalid;
		ans_slot  = '0;
		ans_count = '0;
		case (op_q)
			ctb_pkg::OpStart: begin
				if (free_found) begin
					ans_kind = ctb_pkg::KindStarted;
					ans_slot = 4'(free_idx);
				end else begin
					ans_kind = ctb_pkg::KindNoFree;
				end
			end
			ctb_pkg::OpCancel: begin
				if (!idx_bad) begin
					ans_kind = ctb_pkg::KindCancelled;
					ans_slot = 4'(ptr_q);
				end
			end
			ctb_pkg::OpQuery: begin
				if (!idx_bad) begin
					ans_kind  = ctb_pkg::KindRemaining;
					ans_slot  = 4'(ptr_q);
					ans_count = cnt_rd;
				end
			end
			default: begin
				ans_kind = ctb_pkg::KindInvalid;
			end
		endcase
	end

	assign do_start  = cmd.exec_answer && (op_q == ctb_pkg::OpStart) && free_found;
	assign do_cancel = cmd.exec_answer && (op_q == ctb_pkg::OpCancel) && !idx_bad;
	assign push_scan = cmd.scan_step && hit && pend_valid_q;
	assign push_any  = cmd.exec_answer || push_scan || cmd.flush_push;

	// Status back to the controller.
	always_comb begin
		sts            = '0;
		sts.is_update  = (op_q == ctb_pkg::OpUpdate);
		sts.hit        = hit;
		sts.scan_block = hit && pend_valid_q && !out_free;
		sts.scan_end   = (ptr_q == SW'(NS - 1));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	// Control state with reset: period, clock, slot flags and counts, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= ctb_pkg::ResetPeriod;
			clock_q      <= '0;
			prev_q       <= '0;
			running_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				period_q <= tick_period_ms;
			end
			if (cmd.clock_step) begin
				clock_q <= clock_q + {32'd0, elapsed};
				prev_q  <= now_q;
			end
			if (do_start) begin
				running_q[free_idx] <= 1'b1;
				count_q[free_idx]   <= start_cnt;
			end
			if (do_cancel) begin
				running_q[ptr_q] <= 1'b0;
			end
			if (cmd.scan_step && hit) begin
				count_q[ptr_q] <= cnt_dec;
				if (!cnt_pos) begin
					running_q[ptr_q] <= 1'b0;
				end
				pend_valid_q <= 1'b1;
			end else if (cmd.flush_push) begin
				pend_valid_q <= 1'b0;
			end
			if (push_any) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: latched item, deadlines, held result, output fields.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= operation;
			tenths_q <= tenths;
			idx_q    <= timer_index;
			now_q    <= raw_ticks;
			nres_q   <= '0;
			ptr_q    <= (operation == ctb_pkg::OpUpdate) ? '0 : timer_index[SW-1:0];
		end else if (cmd.scan_step) begin
			ptr_q <= ptr_q + SW'(1);
			if (hit) begin
				nres_q <= nres_q + RW'(1);
			end
		end
		if (do_start) begin
			deadline_q[free_idx] <= clock_q + {48'd0, period_q};
		end else if (cmd.scan_step && hit && cnt_pos) begin
			deadline_q[ptr_q] <= dl_next;
		end
		if (cmd.scan_step && hit) begin
			pend_kind_q  <= cnt_pos ? ctb_pkg::KindTick : ctb_pkg::KindFinished;
			pend_slot_q  <= 4'(ptr_q);
			pend_count_q <= cnt_dec;
		end
		if (cmd.exec_answer) begin
			out_kind_q  <= ans_kind;
			out_slot_q  <= ans_slot;
			out_count_q <= ans_count;
			out_last_q  <= 1'b1;
		end else if (push_scan || cmd.flush_push) begin
			out_kind_q  <= pend_kind_q;
			out_slot_q  <= pend_slot_q;
			out_count_q <= pend_count_q;
			out_last_q  <= cmd.flush_push;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign slot            = out_slot_q;
	assign remaining_count = out_count_q;
	assign last            = out_last_q;

endmodule

`default_nettype wire

FILE: bench/countdown_timer_bank_checker.sv
// Scoreboard for the countdown timer bank: watches the period write, request and
// event channels, keeps its own copy of the slot state and compares every event.
// Depends on ctb_pkg.
module countdown_timer_bank_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [15:0]       tick_period_ms,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [15:0]       tenths,
	input  wire logic signed [4:0] timer_index,
	input  wire logic [31:0]       raw_ticks,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [2:0]        kind,
	input  wire logic [3:0]        slot,
	input  wire logic signed [16:0] remaining_count,
	input  wire logic              last,
	output int                     fail_count,
	output int                     events_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         slot;
		logic signed [16:0] remaining;
		logic               last;
	} timer_event_t;

	// Shadow copy of the bank.
	logic [15:0]        period;
	logic               armed [ctb_pkg::NumSlots];
	logic signed [16:0] count_left [ctb_pkg::NumSlots];
	logic [63:0]        deadline [ctb_pkg::NumSlots];
	logic [63:0]        clock_ms;
	logic [31:0]        prev_ticks;

	// Events predicted but not yet seen, oldest first.
	timer_event_t owed_q [$];
	timer_event_t want;

	function automatic timer_event_t make_event(input logic [2:0] k, input logic [3:0] s,
			input logic signed [16:0] c);
		timer_event_t e;
		e.kind      = k;
		e.slot      = s;
		e.remaining = c;
		e.last      = 1'b0;
		return e;
	endfunction

	// Apply one request to the shadow bank and queue the events it causes.
	task automatic apply_request(input logic [1:0] op, input logic [15:0] ten,
			input logic signed [4:0] idx, input logic [31:0] now);
		timer_event_t found [ctb_pkg::MaxResults];
		int n;
		int i;
		logic [31:0] elapsed;
		logic bad_slot;
		n = 0;
		bad_slot = (idx < 0) || (idx >= ctb_pkg::NumSlots);
		case (op)
			ctb_pkg::OpStart: begin
				i = 0;
				while (i < ctb_pkg::NumSlots && armed[i])
					i++;
				if (i == ctb_pkg::NumSlots) begin
					found[n] = make_event(ctb_pkg::KindNoFree, 4'd0, 17'sd0);
				end else begin
					armed[i]      = 1'b1;
					deadline[i]   = clock_ms + {48'd0, period};
					count_left[i] = $signed({1'b0, ten}) - 17'sd1;
					found[n]      = make_event(ctb_pkg::KindStarted, i[3:0], 17'sd0);
				end
				n++;
			end
			ctb_pkg::OpCancel: begin
				if (bad_slot) begin
					found[n] = make_event(ctb_pkg::KindInvalid, 4'd0, 17'sd0);
				end else begin
					armed[idx] = 1'b0;
					found[n]   = make_event(ctb_pkg::KindCancelled, idx[3:0], 17'sd0);
				end
				n++;
			end
			ctb_pkg::OpQuery: begin
				if (bad_slot)
					found[n] = make_event(ctb_pkg::KindInvalid, 4'd0, 17'sd0);
				else
					found[n] = make_event(ctb_pkg::KindRemaining, idx[3:0],
						count_left[idx]);
				n++;
			end
			default: begin
				// Time update: wrapped difference feeds the 64-bit clock, then an
				// ascending scan over slots whose deadline is strictly passed.
				elapsed    = now - prev_ticks;
				prev_ticks = now;
				clock_ms   = clock_ms + {32'd0, elapsed};
				for (i = 0; i < ctb_pkg::NumSlots && n < ctb_pkg::MaxResults; i++) begin
					if (armed[i] && clock_ms > deadline[i]) begin
						count_left[i] = count_left[i] - 17'sd1;
						if (count_left[i] > 0) begin
							deadline[i] = deadline[i] + {48'd0, period};
							found[n] = make_event(ctb_pkg::KindTick, i[3:0], count_left[i]);
						end else begin
							armed[i] = 1'b0;
							found[n] = make_event(ctb_pkg::KindFinished, i[3:0],
								count_left[i]);
						end
						n++;
					end
				end
			end
		endcase
		if (n > 0)
			found[n - 1].last = 1'b1;
		for (i = 0; i < n; i++)
			owed_q.insert(owed_q.size(), found[i]);
	endtask

	// Compare event transfers, track period writes and predict each request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period     = ctb_pkg::ResetPeriod;
			clock_ms   = '0;
			prev_ticks = '0;
			fail_count = 0;
			for (int k = 0; k < ctb_pkg::NumSlots; k++) begin
				armed[k]      = 1'b0;
				count_left[k] = '0;
				deadline[k]   = '0;
			end
			owed_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					$error("unexpected event: kind %0d slot %0d remaining_count %0d last %0d",
						kind, slot, remaining_count, last);
					fail_count++;
				end else begin
					want = owed_q[0];
					owed_q.delete(0);
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						fail_count++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, slot);
						fail_count++;
					end
					if (remaining_count !== want.remaining) begin
						$error("remaining_count: expected %0d, got %0d",
							want.remaining, remaining_count);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				period = tick_period_ms;
			if (in_valid && !in_stall)
				apply_request(operation, tenths, timer_index, raw_ticks);
		end
		events_owed = owed_q.size();
	end

endmodule

FILE: bench/countdown_timer_bank_tb.sv
// Testbench top for the countdown timer bank: clock, reset, request and period
// stimulus, output backpressure, watchdog and verdict.
// Depends on ctb_pkg, countdown_timer_bank and countdown_timer_bank_checker.
module countdown_timer_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles   = 25;
	localparam int ItemsPerPhase = 67;
	localparam int NumPhases     = 6;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [15:0]       cfg_period;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [15:0]       tenths;
	logic signed [4:0] timer_index;
	logic [31:0]       raw_ticks;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        kind;
	logic [3:0]        slot;
	logic signed [16:0] remaining_count;
	logic              last;

	int          fail_count;
	int          events_owed;
	int          idle_cycles = 0;
	logic [15:0] cur_period;
	bit          calm;
	logic [31:0] tick_now;

	// 2 ns clock.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	countdown_timer_bank i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.tick_period_ms  (cfg_period),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.tenths          (tenths),
		.timer_index     (timer_index),
		.raw_ticks       (raw_ticks),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.slot            (slot),
		.remaining_count (remaining_count),
		.last            (last)
	);

	countdown_timer_bank_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.tick_period_ms  (cfg_period),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.tenths          (tenths),
		.timer_index     (timer_index),
		.raw_ticks       (raw_ticks),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.slot            (slot),
		.remaining_count (remaining_count),
		.last            (last),
		.fail_count      (fail_count),
		.events_owed     (events_owed)
	);

	// Output backpressure in random bursts, switched off for the final phase.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One request transfer, optionally preceded by a random gap.
	task automatic send_request(input logic [1:0] op, input logic [15:0] ten,
			input logic signed [4:0] idx, input logic [31:0] now);
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		operation   = op;
		tenths      = ten;
		timer_index = idx;
		raw_ticks   = now;
		in_valid    = 1'b1;
		if (op == ctb_pkg::OpUpdate)
			tick_now = now;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drain the bank, let a quiet update finish its scan, then write the period.
	task automatic write_period(input logic [15:0] value);
		@(negedge clk);
		in_valid = 1'b0;
		while (events_owed != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		cfg_period = value;
		cfg_valid  = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid  = 1'b0;
		cur_period = value;
	endtask

	// Random request: mostly short counts and time steps on the scale of the
	// period so timers really tick and finish; some full-range noise.
	task automatic send_random();
		int pick;
		int shape;
		logic [1:0] op;
		logic [15:0] ten;
		logic signed [4:0] idx;
		logic [31:0] now;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = ctb_pkg::OpStart;
		else if (pick < 45)
			op = ctb_pkg::OpCancel;
		else if (pick < 63)
			op = ctb_pkg::OpQuery;
		else
			op = ctb_pkg::OpUpdate;
		shape = $urandom_range(0, 9);
		if (shape < 7)
			ten = 16'($urandom_range(0, 6));
		else if (shape < 9)
			ten = 16'($urandom);
		else
			ten = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		if ($urandom_range(0, 4) == 0)
			idx = 5'($urandom);
		else
			idx = 5'($urandom_range(0, ctb_pkg::NumSlots - 1));
		shape = $urandom_range(0, 19);
		if (op != ctb_pkg::OpUpdate || shape == 0)
			now = $urandom;
		else if (shape == 1)
			now = tick_now;
		else
			now = tick_now + $urandom_range(0, cur_period * 2 + 3);
		send_request(op, ten, idx, now);
	endtask

	initial begin
		int phase_periods [NumPhases];
		phase_periods = '{1, 65535, 0, 37, 2, 100};
		phase_periods[4] = $urandom_range(2, 65534);

		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_period  = '0;
		in_valid    = 1'b0;
		operation   = ctb_pkg::OpStart;
		tenths      = '0;
		timer_index = '0;
		raw_ticks   = '0;
		calm        = 1'b0;
		cur_period  = ctb_pkg::ResetPeriod;
		tick_now    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset period. Query of a slot never started,
		// negative indexes, and cancel of an idle slot.
		send_request(ctb_pkg::OpQuery, 16'($urandom), 5'sd0, $urandom);
		send_request(ctb_pkg::OpQuery, 16'($urandom), -5'sd1, $urandom);
		send_request(ctb_pkg::OpCancel, 16'($urandom), 5'sb10000, $urandom);
		send_request(ctb_pkg::OpCancel, 16'($urandom), 5'sd15, $urandom);
		// Zero count, largest count, count of one.
		send_request(ctb_pkg::OpStart, 16'h0000, 5'($urandom), $urandom);
		send_request(ctb_pkg::OpStart, 16'hFFFF, 5'($urandom), $urandom);
		send_request(ctb_pkg::OpStart, 16'h0001, 5'($urandom), $urandom);
		send_request(ctb_pkg::OpQuery, 16'($urandom), 5'sd1, $urandom);
		// Deadline reached but not passed gives a quiet update; one more
		// millisecond expires all three.
		send_request(ctb_pkg::OpUpdate, 16'($urandom), 5'($urandom), 32'd100);
		send_request(ctb_pkg::OpUpdate, 16'($urandom), 5'($urandom), 32'd101);
		// Fill the bank, then one start too many.
		repeat (15) send_request(ctb_pkg::OpStart, 16'h0001, 5'($urandom), $urandom);
		send_request(ctb_pkg::OpStart, 16'($urandom), 5'($urandom), $urandom);
		// Every slot expires at once, then the tick value wraps around.
		send_request(ctb_pkg::OpUpdate, 16'($urandom), 5'($urandom), 32'hFFFF_FFFF);
		send_request(ctb_pkg::OpUpdate, 16'($urandom), 5'($urandom), 32'd5);

		// Random phases, one per period setting; the last one runs without gaps.
		for (int p = 0; p < NumPhases; p++) begin
			write_period(16'(phase_periods[p]));
			if (p == NumPhases - 1)
				calm = 1'b1;
			repeat (ItemsPerPhase) send_random();
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (events_owed != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: countdown_timer_bank.f
src/ctb_pkg.sv
src/ctb_ctrl.sv
src/ctb_datapath.sv
src/countdown_timer_bank.sv
bench/countdown_timer_bank_checker.sv
bench/countdown_timer_bank_tb.sv
